// File: src/flagged_offset_field_packer_defines.svh
// assertion macros shared by the packer modules
`ifndef FLAGGED_OFFSET_FIELD_PACKER_DEFINES_SVH
`define FLAGGED_OFFSET_FIELD_PACKER_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define FOP_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define FOP_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: src/fop_pkg.sv
`default_nettype none

package fop_pkg;

    // default sizes
    localparam int DEF_VALUE_BITS = 64;
    localparam int DEF_COUNT_BITS = 32;
    localparam int DEF_JOB_DEPTH  = 4;
    localparam int DEF_RES_DEPTH  = 2;

    // fixed register and header widths
    localparam int FW_BITS       = 7;
    localparam int ELEM_BITS     = 32;
    localparam int WBYTE_BITS    = 8;
    localparam int HDR_BITS      = ELEM_BITS + WBYTE_BITS;
    localparam int CFG_DATA_BITS = 32;
    localparam int BYTE_BITS     = 8;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_FIELD_WIDTH   = 1'b0,
        CFG_ELEMENT_COUNT = 1'b1
    } t_cfg_reg;

    // classification of one accepted value
    typedef struct packed {
        logic               hdr;
        logic               flag;
        logic               too_wide;
        logic               last;
        logic [FW_BITS-1:0] w;
    } t_job_ctl;

    // one result word
    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 byte_valid;
        logic                 item_done;
        logic                 stream_done;
        logic                 too_wide;
    } t_result;

endpackage

`default_nettype wire

// File: src/fop_fifo.sv
`default_nettype none
`include "flagged_offset_field_packer_defines.svh"

module fop_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = AW + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    // handshake
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd];

    // pointer and fill update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    // checks
    `FOP_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "fifo fill above depth")
    `FOP_ASSERT_NEXT(a_count_inc, do_push && !do_pop, r_count == $past(r_count) + CW'(1),
        "fifo fill did not grow on push")

endmodule

`default_nettype wire

// File: src/fop_front.sv
`default_nettype none
`include "flagged_offset_field_packer_defines.svh"

module fop_front #(
    parameter int VALUE_BITS = fop_pkg::DEF_VALUE_BITS,
    parameter int COUNT_BITS = fop_pkg::DEF_COUNT_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire fop_pkg::t_cfg_reg                  i_cfg_index,
    input  wire logic [fop_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  wire logic                               i_push,
    input  wire logic [VALUE_BITS-1:0]              i_value,
    input  wire logic                               i_job_full,
    output logic                                    o_job_push,
    output fop_pkg::t_job_ctl                       o_job_ctl,
    output logic [COUNT_BITS-1:0]                   o_job_count,
    output logic [VALUE_BITS-1:0]                   o_job_field
);
    import fop_pkg::*;

    logic [FW_BITS-1:0]    r_field_width;
    logic [ELEM_BITS-1:0]  r_element_count;
    logic [ELEM_BITS-1:0]  r_seen, n_seen;
    logic                  r_hdr_sent, n_hdr_sent;

    logic [FW_BITS-1:0]    w_cap;
    logic [VALUE_BITS-1:0] diff;
    logic                  flag;
    logic [ELEM_BITS-1:0]  seen_inc;
    logic                  last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width   <= '0;
            r_element_count <= ELEM_BITS'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FIELD_WIDTH:   r_field_width   <= i_cfg_wdata[FW_BITS-1:0];
                CFG_ELEMENT_COUNT: r_element_count <= i_cfg_wdata[ELEM_BITS-1:0];
                default:           r_field_width   <= r_field_width;
            endcase
        end
    end

    // classify the value: flag, truncation and msb-aligned field
    assign w_cap    = (r_field_width > FW_BITS'(VALUE_BITS)) ? FW_BITS'(VALUE_BITS)
                                                             : r_field_width;
    assign diff     = i_value - VALUE_BITS'(2);
    assign flag     = i_value > VALUE_BITS'(1);
    assign seen_inc = r_seen + ELEM_BITS'(1);
    assign last     = (seen_inc == r_element_count);

    assign o_job_push       = i_push && !i_job_full;
    assign o_job_ctl.hdr      = !r_hdr_sent;
    assign o_job_ctl.flag     = flag;
    assign o_job_ctl.too_wide = flag && ((diff >> w_cap) != '0);
    assign o_job_ctl.last     = last;
    assign o_job_ctl.w        = w_cap;
    assign o_job_count      = r_element_count[COUNT_BITS-1:0];
    assign o_job_field      = flag ? (diff << (FW_BITS'(VALUE_BITS) - w_cap)) : '0;

    // stream position
    always_comb begin
        n_seen     = r_seen;
        n_hdr_sent = r_hdr_sent;
        if (o_job_push) begin
            if (last) begin
                n_seen     = '0;
                n_hdr_sent = 1'b0;
            end else begin
                n_seen     = seen_inc;
                n_hdr_sent = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_hdr_sent <= 1'b0;
        end else begin
            r_seen     <= n_seen;
            r_hdr_sent <= n_hdr_sent;
        end
    end

    // checks
    `FOP_ASSERT_NEXT(a_stream_restart, o_job_push && last, (r_seen == '0) && !r_hdr_sent,
        "stream end did not rewind position")

endmodule

`default_nettype wire

// File: src/fop_back.sv
`default_nettype none
`include "flagged_offset_field_packer_defines.svh"

module fop_back #(
    parameter int VALUE_BITS = fop_pkg::DEF_VALUE_BITS,
    parameter int COUNT_BITS = fop_pkg::DEF_COUNT_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_job_empty,
    input  wire fop_pkg::t_job_ctl     i_job_ctl,
    input  wire logic [COUNT_BITS-1:0] i_job_count,
    input  wire logic [VALUE_BITS-1:0] i_job_field,
    output logic                       o_job_pop,
    input  wire logic                  i_res_full,
    output logic                       o_res_push,
    output fop_pkg::t_result           o_result
);
    import fop_pkg::*;

    localparam int SRC_W = HDR_BITS + 1 + VALUE_BITS;
    localparam int LEN_W = $clog2(SRC_W + 1);

    logic                 r_busy, n_busy;
    logic [SRC_W-1:0]     r_src, n_src;
    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_last, n_last;
    logic                 r_too_wide, n_too_wide;
    logic [FW_BITS-1:0]   r_hbits, n_hbits;
    logic [2:0]           r_hcnt, n_hcnt;

    logic [SRC_W-1:0]     load_src;
    logic [LEN_W-1:0]     load_len;
    logic [BYTE_BITS-1:0] top8, next8, out_cat;
    logic [3:0]           need;
    logic                 long_step, long_done;
    logic [SRC_W-1:0]     src_sh;
    logic [LEN_W-1:0]     rem;
    logic [FW_BITS-1:0]   merge_long, merge_short;

    // job load: left-aligned bit string with its length
    always_comb begin
        if (i_job_ctl.hdr) begin
            load_src = {ELEM_BITS'(i_job_count), WBYTE_BITS'(i_job_ctl.w), i_job_ctl.flag,
                        i_job_field};
            load_len = LEN_W'(HDR_BITS + 1);
        end else begin
            load_src = {i_job_ctl.flag, i_job_field, HDR_BITS'(0)};
            load_len = LEN_W'(1);
        end
        if (i_job_ctl.flag) begin
            load_len = load_len + LEN_W'(i_job_ctl.w);
        end
    end

    // byte assembly from held bits and the head of the bit string
    assign top8       = r_src[SRC_W-1 -: BYTE_BITS];
    assign need       = 4'(BYTE_BITS) - {1'b0, r_hcnt};
    assign long_step  = (r_len >= LEN_W'(need));
    assign out_cat    = BYTE_BITS'((16'(r_hbits) << need) | (16'(top8) >> r_hcnt));
    assign src_sh     = r_src << need;
    assign rem        = r_len - LEN_W'(need);
    assign next8      = src_sh[SRC_W-1 -: BYTE_BITS];
    assign long_done  = (rem < LEN_W'(BYTE_BITS)) && !(r_last && (rem != '0));
    assign merge_long = FW_BITS'(16'(next8) >> (4'(BYTE_BITS) - {1'b0, rem[2:0]}));
    assign merge_short = FW_BITS'((16'(r_hbits) << r_len[2:0])
                                  | (16'(top8) >> (4'(BYTE_BITS) - {1'b0, r_len[2:0]})));

    // handshakes
    assign o_job_pop  = !r_busy && !i_job_empty;
    assign o_res_push = r_busy && !i_res_full;

    // result word
    always_comb begin
        o_result.too_wide = r_too_wide;
        if (long_step) begin
            o_result.out_byte    = out_cat;
            o_result.byte_valid  = 1'b1;
            o_result.item_done   = long_done;
            o_result.stream_done = long_done && r_last;
        end else if (r_last) begin
            o_result.out_byte    = out_cat;
            o_result.byte_valid  = 1'b1;
            o_result.item_done   = 1'b1;
            o_result.stream_done = 1'b1;
        end else begin
            o_result.out_byte    = '0;
            o_result.byte_valid  = 1'b0;
            o_result.item_done   = 1'b1;
            o_result.stream_done = 1'b0;
        end
    end

    // emitter state
    always_comb begin
        n_busy     = r_busy;
        n_src      = r_src;
        n_len      = r_len;
        n_last     = r_last;
        n_too_wide = r_too_wide;
        n_hbits    = r_hbits;
        n_hcnt     = r_hcnt;
        if (o_job_pop) begin
            n_busy     = 1'b1;
            n_src      = load_src;
            n_len      = load_len;
            n_last     = i_job_ctl.last;
            n_too_wide = i_job_ctl.too_wide;
        end else if (o_res_push) begin
            if (long_step) begin
                n_src = src_sh;
                n_len = rem;
                if (long_done) begin
                    n_busy  = 1'b0;
                    n_hbits = merge_long;
                    n_hcnt  = rem[2:0];
                end else begin
                    n_hbits = '0;
                    n_hcnt  = '0;
                end
            end else begin
                n_busy = 1'b0;
                if (r_last) begin
                    n_hbits = '0;
                    n_hcnt  = '0;
                end else begin
                    n_hbits = merge_short;
                    n_hcnt  = r_hcnt + r_len[2:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_hbits <= '0;
            r_hcnt  <= '0;
        end else begin
            r_busy  <= n_busy;
            r_hbits <= n_hbits;
            r_hcnt  <= n_hcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_len      <= n_len;
        r_last     <= n_last;
        r_too_wide <= n_too_wide;
    end

    // checks
    `FOP_ASSERT_NEXT(a_stream_flush, o_res_push && o_result.stream_done,
        (r_hcnt == '0) && (r_hbits == '0), "held bits left after stream end")
    `FOP_ASSERT_NEXT(a_item_release, o_res_push && o_result.item_done, !r_busy,
        "emitter still busy after last word of item")
    `FOP_ASSERT_SAME(a_status_only, o_res_push && !o_result.byte_valid,
        o_result.item_done && !r_last, "status word outside a short item")

endmodule

`default_nettype wire

// File: src/flagged_offset_field_packer.sv
// with the emitter idle, an accepted value is queued, loaded into the emitter, and its
//   first word then pushed to the result queue; the emitter holds one value at a time;
//   one byte leaves per cycle while the result queue has room, up to 14 bytes when a
//   header opens a stream; the job queue between classifier and emitter lets input keep flowing
// reset: synchronous active-low; clears stream position, held bits, queues, and sets
//   field_width 0 and element_count 1
`default_nettype none

module flagged_offset_field_packer #(
    parameter int VALUE_BITS = fop_pkg::DEF_VALUE_BITS,
    parameter int COUNT_BITS = fop_pkg::DEF_COUNT_BITS,
    parameter int JOB_DEPTH  = fop_pkg::DEF_JOB_DEPTH,
    parameter int RES_DEPTH  = fop_pkg::DEF_RES_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire fop_pkg::t_cfg_reg                  i_cfg_index,
    input  wire logic [fop_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [VALUE_BITS-1:0]              i_value,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [fop_pkg::BYTE_BITS-1:0]           o_out_byte,
    output logic                                    o_byte_valid,
    output logic                                    o_item_done,
    output logic                                    o_stream_done,
    output logic                                    o_value_too_wide
);
    import fop_pkg::*;

    localparam int CTL_W = $bits(t_job_ctl);
    localparam int JOB_W = CTL_W + COUNT_BITS + VALUE_BITS;
    localparam int RES_W = $bits(t_result);

    logic                  job_push, job_full, job_pop, job_empty;
    t_job_ctl              fe_ctl, be_ctl;
    logic [COUNT_BITS-1:0] fe_count, be_count;
    logic [VALUE_BITS-1:0] fe_field, be_field;
    logic [JOB_W-1:0]      job_wdata, job_rdata;
    logic                  res_push, res_full;
    t_result               be_result, res_head;
    logic [RES_W-1:0]      res_rdata;

    // classifier and stream position
    fop_front #(
        .VALUE_BITS(VALUE_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_value     (i_value),
        .i_job_full  (job_full),
        .o_job_push  (job_push),
        .o_job_ctl   (fe_ctl),
        .o_job_count (fe_count),
        .o_job_field (fe_field)
    );

    assign full      = job_full;
    assign job_wdata = {fe_ctl, fe_count, fe_field};

    // job queue between classifier and emitter
    fop_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_wdata (job_wdata),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_rdata (job_rdata),
        .o_empty (job_empty)
    );

    assign be_ctl   = t_job_ctl'(job_rdata[JOB_W-1 -: CTL_W]);
    assign be_count = job_rdata[VALUE_BITS +: COUNT_BITS];
    assign be_field = job_rdata[VALUE_BITS-1:0];

    // byte emitter
    fop_back #(
        .VALUE_BITS(VALUE_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job_ctl   (be_ctl),
        .i_job_count (be_count),
        .i_job_field (be_field),
        .o_job_pop   (job_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_result    (be_result)
    );

    // result queue toward the consumer
    fop_fifo #(
        .WIDTH(RES_W),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (be_result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_empty (empty)
    );

    assign res_head         = t_result'(res_rdata);
    assign o_out_byte       = res_head.out_byte;
    assign o_byte_valid     = res_head.byte_valid;
    assign o_item_done      = res_head.item_done;
    assign o_stream_done    = res_head.stream_done;
    assign o_value_too_wide = res_head.too_wide;

endmodule

`default_nettype wire
